### src/mdag_pkg.sv
// ----------------------------------------------------------------------------
// mdag_pkg
// Shared widths, codes and controller/datapath signal groups for the
// multi-dimensional range address generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mdag_pkg;

  localparam int FIELD_W    = 64;
  localparam int KIND_W     = 3;
  localparam int NUM_DIMS_W = 3;
  localparam int BASIS_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int DIGIT_BITS = 16;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_NEXT        = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PREV        = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MOVE_TARGET = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MOVE_START  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MOVE_LAST   = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASIS_DIM   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZES   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_POINT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_END_POINT   = 3'd4;

  typedef struct packed {
    logic sweep_begin;  // restart stride computation
    logic sweep_write;  // store running product as stride
    logic sweep_mul;    // running product times extent
    logic sweep_step;   // take product, go one dimension down
    logic accept;       // latch request
    logic step_mul;     // start delta times stride
    logic step_apply;   // commit coordinate and position
    logic carry_move;   // advance dimension pointer
    logic mark_wrap;    // carry wrapped round to basis
    logic move_done;    // set flags after a move
    logic load_out;     // load output register
  } dp_cmd_t;

  typedef struct packed {
    logic dirty;        // strides out of date
    logic mul_busy;
    logic kind_next;
    logic kind_prev;
    logic kind_move;
    logic blocked;      // step refused by its flag
    logic carry_stop;   // this dimension absorbs the step
    logic carry_wrap;   // next carry dimension is the basis
    logic last_dim;
    logic sweep_last;
  } dp_status_t;

endpackage

`default_nettype wire

### src/mdag_req_if.sv
// ----------------------------------------------------------------------------
// mdag_req_if
// Request channel: command kind and move target.
// ----------------------------------------------------------------------------
`default_nettype none

interface mdag_req_if;
  import mdag_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [FIELD_W-1:0]  target_coord;

  modport source (output valid, kind, target_coord, input ready);
  modport sink   (input valid, kind, target_coord, output ready);
endinterface

`default_nettype wire

### src/mdag_rsp_if.sv
// ----------------------------------------------------------------------------
// mdag_rsp_if
// Result channel: coordinate, linear position and walk flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface mdag_rsp_if;
  import mdag_pkg::*;

  logic                valid;
  logic                ready;
  logic [FIELD_W-1:0]  current_coord;
  logic [FIELD_W-1:0]  linear_position;
  logic                at_end;
  logic                at_front;

  modport source (output valid, current_coord, linear_position, at_end, at_front,
                  input ready);
  modport sink   (input valid, current_coord, linear_position, at_end, at_front,
                  output ready);
endinterface

`default_nettype wire

### src/mdag_mul.sv
// ----------------------------------------------------------------------------
// mdag_mul
// Digit-serial multiplier: 64-bit operand times an unsigned B_W-bit operand,
// result modulo 2^64, one 16-bit digit of the short operand per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mdag_mul #(
  parameter int B_W = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [mdag_pkg::FIELD_W-1:0] a,
  input  wire logic [B_W-1:0]              b,
  output      logic                        busy,
  output      logic [mdag_pkg::FIELD_W-1:0] prod
);
  import mdag_pkg::*;

  localparam int ND = (B_W + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int BP = ND * DIGIT_BITS;
  localparam int CW = $clog2(ND + 1);

  logic [FIELD_W-1:0] acc;
  logic [FIELD_W-1:0] a_sh;
  logic [BP-1:0]      b_sh;
  logic [CW-1:0]      cnt;
  logic               running;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
    end else if (start) begin
      running <= 1'b1;
      cnt     <= CW'(ND);
    end else if (running) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= '0;
      a_sh <= a;
      b_sh <= BP'(b);
    end else if (running) begin
      acc  <= acc + a_sh * FIELD_W'(b_sh[DIGIT_BITS-1:0]);
      a_sh <= a_sh << DIGIT_BITS;
      b_sh <= b_sh >> DIGIT_BITS;
    end
  end

  assign busy = running;
  assign prod = acc;

endmodule

`default_nettype wire

### src/mdag_dp.sv
// ----------------------------------------------------------------------------
// mdag_dp
// Datapath: configuration registers, stride table, coordinate and position
// state, carry walk logic and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mdag_dp #(
  parameter int MAX_DIMS   = 4,
  parameter int COORD_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [mdag_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [mdag_pkg::FIELD_W-1:0]   cfg_data,
  input  wire logic [mdag_pkg::KIND_W-1:0]    req_kind,
  input  wire logic [mdag_pkg::FIELD_W-1:0]   req_target,
  input  wire mdag_pkg::dp_cmd_t             cmd,
  output      mdag_pkg::dp_status_t          status,
  output      logic [mdag_pkg::FIELD_W-1:0]   out_coord,
  output      logic [mdag_pkg::FIELD_W-1:0]   out_position,
  output      logic                          out_end,
  output      logic                          out_front
);
  import mdag_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int IW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int DW = $clog2(MAX_DIMS + 1);
  localparam int PW = MAX_DIMS * CB + FIELD_W;

  // configuration
  logic [NUM_DIMS_W-1:0] num_dims;
  logic [BASIS_W-1:0]    basis_dim;
  logic [FIELD_W-1:0]    dim_sizes;
  logic [FIELD_W-1:0]    start_point;
  logic [FIELD_W-1:0]    end_point;
  logic                  dirty;

  // walk state
  logic [CB-1:0]      coord [MAX_DIMS];
  logic [FIELD_W-1:0] position;
  logic               end_flag;
  logic               front_flag;

  // working registers
  logic [KIND_W-1:0]  kind;
  logic [FIELD_W-1:0] target;
  logic [IW-1:0]      cur;
  logic [IW-1:0]      sd;
  logic [FIELD_W-1:0] run;
  logic [FIELD_W-1:0] stride [MAX_DIMS];

  // unpacked fields
  logic [PW-1:0] size_w, start_w, end_w, target_w, out_w;
  logic [CB-1:0] size_f  [MAX_DIMS];
  logic [CB-1:0] start_f [MAX_DIMS];
  logic [CB-1:0] end_f   [MAX_DIMS];
  logic [CB-1:0] last_f  [MAX_DIMS];
  logic [CB-1:0] tgt_f   [MAX_DIMS];

  logic [DW-1:0] nd;
  logic [IW-1:0] nd_m1;
  logic [IW-1:0] b_idx;
  logic [IW-1:0] cur_prev;

  logic          kind_next, kind_prev, kind_move, req_move;
  logic [CB-1:0] coord_cur;
  logic [CB:0]   inc_ext;
  logic          fits_next, above;
  logic [CB-1:0] new_val;
  logic          neg;
  logic [CB-1:0] mag;
  logic          at_start;

  logic               mul_start;
  logic [FIELD_W-1:0] mul_a;
  logic [CB-1:0]      mul_b;
  logic               mul_busy;
  logic [FIELD_W-1:0] mul_prod;

  assign size_w   = PW'(dim_sizes);
  assign start_w  = PW'(start_point);
  assign end_w    = PW'(end_point);
  assign target_w = PW'(target);

  assign kind_next = (kind == KIND_NEXT);
  assign kind_prev = (kind == KIND_PREV);
  assign kind_move = (kind == KIND_MOVE_TARGET) || (kind == KIND_MOVE_START) ||
                     (kind == KIND_MOVE_LAST);
  assign req_move  = (req_kind == KIND_MOVE_TARGET) || (req_kind == KIND_MOVE_START) ||
                     (req_kind == KIND_MOVE_LAST);

  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      size_f[d]  = size_w[d*CB +: CB];
      start_f[d] = start_w[d*CB +: CB];
      end_f[d]   = end_w[d*CB +: CB];
      last_f[d]  = end_w[d*CB +: CB] - CB'(1);
      case (kind)
        KIND_MOVE_START: tgt_f[d] = start_w[d*CB +: CB];
        KIND_MOVE_LAST:  tgt_f[d] = end_w[d*CB +: CB] - CB'(1);
        default:         tgt_f[d] = target_w[d*CB +: CB];
      endcase
    end
  end

  // dimension count and basis, clamped
  always_comb begin
    if (num_dims == '0) begin
      nd = DW'(1);
    end else if (int'(num_dims) > MAX_DIMS) begin
      nd = DW'(MAX_DIMS);
    end else begin
      nd = DW'(num_dims);
    end
  end

  assign nd_m1 = IW'(nd - DW'(1));

  always_comb begin
    if (int'(basis_dim) < int'(nd)) begin
      b_idx = IW'(basis_dim);
    end else begin
      b_idx = nd_m1;
    end
  end

  // carry runs towards dimension 0, then wraps to the top
  assign cur_prev = (cur == '0) ? nd_m1 : cur - IW'(1);

  assign coord_cur = coord[cur];
  assign inc_ext   = {1'b0, coord_cur} + {{CB{1'b0}}, 1'b1};
  assign fits_next = inc_ext < {1'b0, end_f[cur]};
  assign above     = coord_cur > start_f[cur];

  always_comb begin
    if (kind_next) begin
      new_val = fits_next ? inc_ext[CB-1:0] : start_f[cur];
    end else if (kind_prev) begin
      new_val = above ? coord_cur - CB'(1) : last_f[cur];
    end else if (kind_move) begin
      new_val = tgt_f[cur];
    end else begin
      new_val = coord_cur;
    end
  end

  assign neg = new_val < coord_cur;
  assign mag = neg ? coord_cur - new_val : new_val - coord_cur;

  // start test sees the value being committed in this cycle
  always_comb begin
    logic [CB-1:0] cv;
    at_start = 1'b1;
    cv       = '0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      cv = (IW'(d) == cur) ? new_val : coord[d];
      if (d < int'(nd) && cv != start_f[d]) begin
        at_start = 1'b0;
      end
    end
  end

  always_comb begin
    out_w = '0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      if (d < int'(nd)) begin
        out_w[d*CB +: CB] = coord[d];
      end
    end
  end

  assign mul_start = cmd.sweep_mul | cmd.step_mul;
  assign mul_a     = cmd.sweep_mul ? run : stride[cur];
  assign mul_b     = cmd.sweep_mul ? size_f[sd] : mag;

  mdag_mul #(
    .B_W (CB)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .prod  (mul_prod)
  );

  // configuration and walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      num_dims    <= NUM_DIMS_W'(4);
      basis_dim   <= BASIS_W'(3);
      dim_sizes   <= '0;
      start_point <= '0;
      end_point   <= '0;
      dirty       <= 1'b1;
      for (int d = 0; d < MAX_DIMS; d++) begin
        coord[d] <= '0;
      end
      position   <= '0;
      end_flag   <= 1'b0;
      front_flag <= 1'b0;
    end else begin
      if (cmd.sweep_begin) begin
        dirty <= 1'b0;
      end
      if (cfg_we) begin
        dirty <= 1'b1;
        unique case (cfg_idx)
          CFG_NUM_DIMS:    num_dims    <= cfg_data[NUM_DIMS_W-1:0];
          CFG_BASIS_DIM:   basis_dim   <= cfg_data[BASIS_W-1:0];
          CFG_DIM_SIZES:   dim_sizes   <= cfg_data;
          CFG_START_POINT: start_point <= cfg_data;
          CFG_END_POINT:   end_point   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.step_mul) begin
        if (kind_next) front_flag <= 1'b0;
        if (kind_prev) end_flag <= 1'b0;
      end
      if (cmd.step_apply) begin
        coord[cur] <= new_val;
        position   <= neg ? position - mul_prod : position + mul_prod;
      end
      if (cmd.mark_wrap) begin
        if (kind_next) begin
          end_flag <= 1'b1;
        end else begin
          front_flag <= 1'b1;
        end
      end
      if (cmd.move_done) begin
        front_flag <= at_start;
        end_flag   <= 1'b0;
      end
    end
  end

  // working registers and output register
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind   <= req_kind;
      target <= req_target;
      cur    <= req_move ? '0 : b_idx;
    end else if (cmd.carry_move) begin
      cur <= kind_move ? cur + IW'(1) : cur_prev;
    end
    if (cmd.sweep_begin) begin
      run <= FIELD_W'(1);
      sd  <= nd_m1;
    end else if (cmd.sweep_step) begin
      run <= mul_prod;
      sd  <= sd - IW'(1);
    end
    if (cmd.sweep_write) begin
      stride[sd] <= run;
    end
    if (cmd.load_out) begin
      out_coord    <= out_w[FIELD_W-1:0];
      out_position <= position;
      out_end      <= end_flag;
      out_front    <= front_flag;
    end
  end

  always_comb begin
    status.dirty      = dirty;
    status.mul_busy   = mul_busy;
    status.kind_next  = kind_next;
    status.kind_prev  = kind_prev;
    status.kind_move  = kind_move;
    status.blocked    = kind_next ? end_flag : front_flag;
    status.carry_stop = kind_next ? fits_next : above;
    status.carry_wrap = (cur_prev == b_idx);
    status.last_dim   = (cur == nd_m1);
    status.sweep_last = (sd == '0);
  end

endmodule

`default_nettype wire

### src/mdag_ctrl.sv
// ----------------------------------------------------------------------------
// mdag_ctrl
// Controller: stride sweep after reset or configuration, per-request carry walk and
// result handover.
// ----------------------------------------------------------------------------
`default_nettype none

module mdag_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output      logic                 req_ready,
  output      logic                 rsp_valid,
  input  wire logic                 rsp_ready,
  input  wire mdag_pkg::dp_status_t status,
  output      mdag_pkg::dp_cmd_t    cmd
);
  import mdag_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SW_SET,
    S_SW_MUL,
    S_EVAL,
    S_MUL,
    S_FINISH
  } state_t;

  state_t state, state_next;

  assign req_ready = (state == S_IDLE) && !status.dirty;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (status.dirty) begin
          cmd.sweep_begin = 1'b1;
          state_next      = S_SW_SET;
        end else if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_SW_SET: begin
        cmd.sweep_write = 1'b1;
        if (status.sweep_last) begin
          state_next = S_IDLE;
        end else begin
          cmd.sweep_mul = 1'b1;
          state_next    = S_SW_MUL;
        end
      end
      S_SW_MUL: begin
        if (!status.mul_busy) begin
          cmd.sweep_step = 1'b1;
          state_next     = S_SW_SET;
        end
      end
      S_EVAL: begin
        if (status.kind_move ||
            ((status.kind_next || status.kind_prev) && !status.blocked)) begin
          cmd.step_mul = 1'b1;
          state_next   = S_MUL;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_MUL: begin
        if (!status.mul_busy) begin
          cmd.step_apply = 1'b1;
          if (status.kind_move) begin
            if (status.last_dim) begin
              cmd.move_done = 1'b1;
              state_next    = S_FINISH;
            end else begin
              cmd.carry_move = 1'b1;
              state_next     = S_EVAL;
            end
          end else if (status.carry_stop) begin
            state_next = S_FINISH;
          end else if (status.carry_wrap) begin
            cmd.mark_wrap = 1'b1;
            state_next    = S_FINISH;
          end else begin
            cmd.carry_move = 1'b1;
            state_next     = S_EVAL;
          end
        end
      end
      S_FINISH: begin
        // hold until the output register is free
        if (!rsp_valid || rsp_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### src/multi_dim_range_address_generator.sv
// A request is taken in S_IDLE; each dimension that it touches then passes S_EVAL and
//   S_MUL in the shared multiplier, and S_FINISH loads the result; unused kinds and
//   refused steps go from S_EVAL straight to S_FINISH.
// One request in flight; the next is taken in S_IDLE once the result is loaded and no
//   stride sweep is pending.
// Reset clears the walk state; reset and every configuration write start a stride sweep
//   through S_SW_SET and S_SW_MUL with req.ready low.
// ----------------------------------------------------------------------------
// multi_dim_range_address_generator
// Walks a sub-box of a row-major N-dimensional array, returning coordinate,
// linear position and front/end flags for every request.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_dim_range_address_generator #(
  parameter int MAX_DIMS   = 4,
  parameter int COORD_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [mdag_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [mdag_pkg::FIELD_W-1:0]   cfg_data,
  mdag_req_if.sink                           req,
  mdag_rsp_if.source                         rsp
);
  import mdag_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       req_ready;
  logic       rsp_valid;

  mdag_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  mdag_dp #(
    .MAX_DIMS   (MAX_DIMS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_data     (cfg_data),
    .req_kind     (req.kind),
    .req_target   (req.target_coord),
    .cmd          (cmd),
    .status       (status),
    .out_coord    (rsp.current_coord),
    .out_position (rsp.linear_position),
    .out_end      (rsp.at_end),
    .out_front    (rsp.at_front)
  );

  assign req.ready = req_ready;
  assign rsp.valid = rsp_valid;

endmodule

`default_nettype wire

### src/mdag_checker.sv
// ----------------------------------------------------------------------------
// mdag_checker
// Port-level checks on the address generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mdag_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [63:0] rsp_position,
  input wire logic        rsp_end,
  input wire logic        rsp_front
);

  // no stale result survives reset
  a_rst_clears_rsp: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // one request at a time: busy straight after taking one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in flight");

  // the walk cannot be past both ends at once
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_end && rsp_front))
    else $error("end and front flags both set");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_position))
    else $error("stalled result changed");

endmodule

bind multi_dim_range_address_generator mdag_checker u_mdag_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_position (rsp.linear_position),
  .rsp_end      (rsp.at_end),
  .rsp_front    (rsp.at_front)
);

`default_nettype wire

### tb/sv/tb_multi_dim_range_address_generator.sv
// ----------------------------------------------------------------------------
// tb_multi_dim_range_address_generator
// Self-checking bench for the range address generator. A short table of
// requests and register writes runs first. Random phases follow, each with its
// own box and mostly forward/backward walks. Every result is compared with an
// in-bench walk predictor, or for the table rows that carry one, with a fixed result.
// ----------------------------------------------------------------------------
module tb_multi_dim_range_address_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import mdag_pkg::*;

  localparam int DIMS         = 4;
  localparam int LIMIT_CYCLES = 200000;
  localparam int PHASES       = 15;
  localparam int PHASE_ITEMS  = 60;
  localparam int QUIET_FROM   = 13;
  localparam int LONG_HOLD    = 120;
  localparam int DRAIN_TAIL   = 40;
  localparam int SCRIPT_ROWS  = 36;

  // kinds and register indexes that the block decodes to nothing
  localparam logic [KIND_W-1:0]    KIND_SPARE_FIRST = 3'd5;
  localparam logic [KIND_W-1:0]    KIND_SPARE_LAST  = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST   = 3'd7;

  typedef struct packed {
    logic [FIELD_W-1:0] coord;
    logic [FIELD_W-1:0] pos;
    logic               at_end;
    logic               at_front;
  } walk_result_t;

  typedef struct {
    bit                 is_cfg;
    logic [KIND_W-1:0]  code;
    logic [FIELD_W-1:0] data;
    bit                 known;
    walk_result_t       want;
  } script_row_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [FIELD_W-1:0]   cfg_data;

  mdag_req_if req_ch ();
  mdag_rsp_if rsp_ch ();

  multi_dim_range_address_generator #(
    .MAX_DIMS   (DIMS),
    .COORD_BITS (DIGIT_BITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  // walk predictor state
  logic [NUM_DIMS_W-1:0] w_num_dims;
  logic [BASIS_W-1:0]    w_basis;
  logic [FIELD_W-1:0]    w_sizes;
  logic [FIELD_W-1:0]    w_start;
  logic [FIELD_W-1:0]    w_end;
  logic [DIGIT_BITS-1:0] w_coord [DIMS];
  logic [FIELD_W-1:0]    w_pos;
  logic                  w_end_flag;
  logic                  w_front_flag;

  walk_result_t expected_results [$];
  int           errors        = 0;
  bit           quiet         = 0;
  bit           hold_request  = 0;
  int unsigned  cycle_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [DIGIT_BITS-1:0] digit_of(logic [FIELD_W-1:0] vec, int d);
    return vec[d*DIGIT_BITS +: DIGIT_BITS];
  endfunction

  function automatic int dims_active();
    if (w_num_dims == 0) return 1;
    if (w_num_dims > DIMS) return DIMS;
    return int'(w_num_dims);
  endfunction

  function automatic int basis_active(int nd);
    return (int'(w_basis) < nd) ? int'(w_basis) : nd - 1;
  endfunction

  function automatic logic [FIELD_W-1:0] stride_of(int d, int nd);
    logic [FIELD_W-1:0] s;
    s = FIELD_W'(1);
    for (int k = d + 1; k < nd; k++) s = s * FIELD_W'(digit_of(w_sizes, k));
    return s;
  endfunction

  function automatic void apply_config(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] val);
    case (idx)
      CFG_NUM_DIMS:    w_num_dims = val[NUM_DIMS_W-1:0];
      CFG_BASIS_DIM:   w_basis    = val[BASIS_W-1:0];
      CFG_DIM_SIZES:   w_sizes    = val;
      CFG_START_POINT: w_start    = val;
      CFG_END_POINT:   w_end      = val;
      default: ;
    endcase
  endfunction

  function automatic void move_to(logic [FIELD_W-1:0] tgt);
    int nd;
    logic at_start;
    logic [DIGIT_BITS-1:0] t;
    nd = dims_active();
    at_start = 1'b1;
    for (int d = 0; d < nd; d++) begin
      t = digit_of(tgt, d);
      w_pos += (FIELD_W'(t) - FIELD_W'(w_coord[d])) * stride_of(d, nd);
      w_coord[d] = t;
      if (t != digit_of(w_start, d)) at_start = 1'b0;
    end
    w_front_flag = at_start;
    w_end_flag   = 1'b0;
  endfunction

  function automatic void step_forward();
    int nd, b, cur;
    logic [FIELD_W-1:0] s;
    logic [DIGIT_BITS-1:0] st;
    bit absorbed;
    nd = dims_active();
    b  = basis_active(nd);
    if (w_end_flag) return;
    w_front_flag = 1'b0;
    cur = b;
    absorbed = 0;
    do begin
      s  = stride_of(cur, nd);
      st = digit_of(w_start, cur);
      if (FIELD_W'(w_coord[cur]) + 1 < FIELD_W'(digit_of(w_end, cur))) begin
        w_coord[cur] += 1'b1;
        w_pos += s;
        absorbed = 1;
      end else begin
        w_pos -= (FIELD_W'(w_coord[cur]) - FIELD_W'(st)) * s;
        w_coord[cur] = st;
        cur = (cur != 0) ? cur - 1 : nd - 1;
      end
    end while (!absorbed && cur != b);
    if (!absorbed) w_end_flag = 1'b1;
  endfunction

  // carries run in the same order as the forward walk
  function automatic void step_back();
    int nd, b, cur;
    logic [FIELD_W-1:0] s;
    logic [DIGIT_BITS-1:0] last;
    bit absorbed;
    nd = dims_active();
    b  = basis_active(nd);
    if (w_front_flag) return;
    w_end_flag = 1'b0;
    cur = b;
    absorbed = 0;
    do begin
      s    = stride_of(cur, nd);
      last = digit_of(w_end, cur) - 1'b1;
      if (w_coord[cur] > digit_of(w_start, cur)) begin
        w_coord[cur] -= 1'b1;
        w_pos -= s;
        absorbed = 1;
      end else begin
        w_pos += (FIELD_W'(last) - FIELD_W'(w_coord[cur])) * s;
        w_coord[cur] = last;
        cur = (cur != 0) ? cur - 1 : nd - 1;
      end
    end while (!absorbed && cur != b);
    if (!absorbed) w_front_flag = 1'b1;
  endfunction

  function automatic walk_result_t walk_cmd(logic [KIND_W-1:0] kind, logic [FIELD_W-1:0] tgt);
    walk_result_t r;
    logic [FIELD_W-1:0] last_vec;
    int nd;
    case (kind)
      KIND_NEXT:        step_forward();
      KIND_PREV:        step_back();
      KIND_MOVE_TARGET: move_to(tgt);
      KIND_MOVE_START:  move_to(w_start);
      KIND_MOVE_LAST: begin
        for (int d = 0; d < DIMS; d++)
          last_vec[d*DIGIT_BITS +: DIGIT_BITS] = digit_of(w_end, d) - 1'b1;
        move_to(last_vec);
      end
      default: ;
    endcase
    nd = dims_active();
    r = '0;
    for (int d = 0; d < nd; d++) r.coord[d*DIGIT_BITS +: DIGIT_BITS] = w_coord[d];
    r.pos      = w_pos;
    r.at_end   = w_end_flag;
    r.at_front = w_front_flag;
    return r;
  endfunction

  function automatic script_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] val);
    script_row_t row;
    row = '{1'b1, idx, val, 1'b0, '0};
    return row;
  endfunction

  function automatic script_row_t cmd_row(logic [KIND_W-1:0] kind, logic [FIELD_W-1:0] tgt);
    script_row_t row;
    row = '{1'b0, kind, tgt, 1'b0, '0};
    return row;
  endfunction

  function automatic script_row_t known_row(logic [KIND_W-1:0] kind, logic [FIELD_W-1:0] coord,
                                            logic [FIELD_W-1:0] pos, logic e, logic f);
    script_row_t row;
    row = '{1'b0, kind, '0, 1'b1, '{coord, pos, e, f}};
    return row;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    apply_config(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // stop offering and wait for every outstanding result
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_request(logic [KIND_W-1:0] kind, logic [FIELD_W-1:0] tgt,
                              bit known, walk_result_t want);
    walk_result_t predicted;
    req_ch.valid        <= 1'b1;
    req_ch.kind         <= kind;
    req_ch.target_coord <= tgt;
    do @(posedge clk); while (!req_ch.ready);
    predicted = walk_cmd(kind, tgt);
    expected_results.push_back(known ? want : predicted);
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic report_field(string name, logic [FIELD_W-1:0] exp_v, logic [FIELD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // result side: random short stalls, plus one long hold-off on demand
  initial begin
    rsp_ch.ready = 1'b1;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 0;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    walk_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual coord %h pos %h end %b front %b",
                 $time, rsp_ch.current_coord, rsp_ch.linear_position, rsp_ch.at_end,
                 rsp_ch.at_front);
        errors++;
      end else begin
        want = expected_results.pop_front();
        report_field("current_coord", want.coord, rsp_ch.current_coord);
        report_field("linear_position", want.pos, rsp_ch.linear_position);
        report_field("at_end", FIELD_W'(want.at_end), FIELD_W'(rsp_ch.at_end));
        report_field("at_front", FIELD_W'(want.at_front), FIELD_W'(rsp_ch.at_front));
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    script_row_t script [SCRIPT_ROWS];
    int unsigned mode, run_left, pick;
    logic [KIND_W-1:0] run_kind, kind;
    logic [FIELD_W-1:0] tgt, sizes, box_start, box_end;
    logic [DIGIT_BITS-1:0] sz, st, span;
    int nd_pick;

    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_idx             = '0;
    cfg_data            = '0;
    req_ch.valid        = 1'b0;
    req_ch.kind         = '0;
    req_ch.target_coord = '0;

    w_num_dims   = 3'd4;
    w_basis      = 2'd3;
    w_sizes      = '0;
    w_start      = '0;
    w_end        = '0;
    w_pos        = '0;
    w_end_flag   = 1'b0;
    w_front_flag = 1'b0;
    for (int d = 0; d < DIMS; d++) w_coord[d] = '0;

    script = '{
      // reset registers: empty box, so a forward step wraps straight to the end
      known_row(KIND_NEXT, '0, '0, 1'b1, 1'b0),
      known_row(KIND_NEXT, '0, '0, 1'b1, 1'b0),
      cmd_row(KIND_PREV, '0),
      known_row(KIND_MOVE_START, '0, '0, 1'b0, 1'b1),
      cmd_row(KIND_SPARE_FIRST, '1),
      // 2-D box (1..2, 1..2) in a 3x4 array
      cfg_row(CFG_NUM_DIMS, 64'd2),
      cfg_row(CFG_BASIS_DIM, 64'd1),
      cfg_row(CFG_DIM_SIZES, 64'h0000_0000_0004_0003),
      cfg_row(CFG_START_POINT, 64'h0000_0000_0001_0001),
      cfg_row(CFG_END_POINT, 64'h0000_0000_0003_0003),
      cmd_row(KIND_MOVE_START, '0),
      cmd_row(KIND_NEXT, '0),
      cmd_row(KIND_NEXT, '0),
      cmd_row(KIND_NEXT, '0),
      cmd_row(KIND_PREV, '0),
      cmd_row(KIND_PREV, '0),
      cmd_row(KIND_MOVE_LAST, '0),
      cmd_row(KIND_NEXT, '0),
      cmd_row(KIND_NEXT, '0),
      cmd_row(KIND_PREV, '0),
      cmd_row(KIND_MOVE_TARGET, '1),
      // basis beyond the dimensions in use
      cfg_row(CFG_BASIS_DIM, 64'd3),
      cmd_row(KIND_NEXT, '0),
      cmd_row(KIND_PREV, '0),
      // zero dimensions behaves as one
      cfg_row(CFG_NUM_DIMS, 64'd0),
      cmd_row(KIND_NEXT, '0),
      cmd_row(KIND_MOVE_TARGET, 64'h1234_5678_9abc_def0),
      // too many dimensions, full-size array, inverted box
      cfg_row(CFG_NUM_DIMS, 64'd7),
      cfg_row(CFG_DIM_SIZES, '1),
      cfg_row(CFG_START_POINT, '1),
      cfg_row(CFG_END_POINT, '0),
      cmd_row(KIND_MOVE_START, '0),
      cmd_row(KIND_PREV, '0),
      cmd_row(KIND_NEXT, '0),
      cmd_row(KIND_MOVE_LAST, '0),
      cmd_row(KIND_SPARE_LAST, '0)
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < SCRIPT_ROWS; i++) begin
      if (script[i].is_cfg) begin
        settle();
        write_reg(script[i].code, script[i].data);
      end else begin
        send_request(script[i].code, script[i].data, script[i].known, script[i].want);
        sender_gap();
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      quiet = (ph >= QUIET_FROM);
      mode  = $urandom_range(0, 9);
      for (int d = 0; d < DIMS; d++) begin
        if (mode < 7) begin
          // well-formed small box
          st   = DIGIT_BITS'($urandom_range(0, 2));
          span = DIGIT_BITS'($urandom_range(1, 3));
          sz   = st + span + DIGIT_BITS'($urandom_range(0, 2));
        end else if (mode == 7) begin
          st   = DIGIT_BITS'($urandom);
          span = DIGIT_BITS'($urandom);
          sz   = DIGIT_BITS'($urandom);
        end else if (mode == 8) begin
          st   = '0;
          span = '1;
          sz   = '1;
        end else begin
          // empty or inverted box
          st   = DIGIT_BITS'($urandom_range(0, 4));
          span = -DIGIT_BITS'($urandom_range(0, 2));
          sz   = DIGIT_BITS'($urandom_range(0, 6));
        end
        sizes[d*DIGIT_BITS +: DIGIT_BITS]     = sz;
        box_start[d*DIGIT_BITS +: DIGIT_BITS] = st;
        box_end[d*DIGIT_BITS +: DIGIT_BITS]   = st + span;
      end
      nd_pick = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
      write_reg(CFG_NUM_DIMS, FIELD_W'(nd_pick));
      write_reg(CFG_BASIS_DIM, FIELD_W'($urandom_range(0, 3)));
      write_reg(CFG_DIM_SIZES, sizes);
      write_reg(CFG_START_POINT, box_start);
      write_reg(CFG_END_POINT, box_end);
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
                  {$urandom, $urandom});

      run_left = 0;
      run_kind = KIND_NEXT;
      for (int it = 0; it < PHASE_ITEMS; it++) begin
        if (ph == 2 && it == 10) hold_request = 1;
        if (ph == 4 && it == 30) settle();
        if (it == 0 && mode < 7) begin
          kind = KIND_MOVE_START;
        end else begin
          if (run_left == 0) begin
            run_left = $urandom_range(1, 20);
            run_kind = $urandom_range(0, 1) ? KIND_NEXT : KIND_PREV;
          end
          run_left--;
          pick = $urandom_range(0, 99);
          if (pick < 75)      kind = run_kind;
          else if (pick < 85) kind = KIND_MOVE_TARGET;
          else if (pick < 90) kind = KIND_MOVE_START;
          else if (pick < 95) kind = KIND_MOVE_LAST;
          else                kind = KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
        end
        if ($urandom_range(0, 2) == 0) begin
          tgt = {$urandom, $urandom};
        end else begin
          for (int d = 0; d < DIMS; d++) begin
            span = digit_of(box_end, d) - digit_of(box_start, d);
            tgt[d*DIGIT_BITS +: DIGIT_BITS] = digit_of(box_start, d)
              + ((span == 0) ? DIGIT_BITS'(0) : DIGIT_BITS'($urandom_range(0, span - 1)));
          end
        end
        send_request(kind, tgt, 1'b0, '0);
        sender_gap();
      end
    end

    settle();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
src/mdag_pkg.sv
src/mdag_req_if.sv
src/mdag_rsp_if.sv
src/mdag_mul.sv
src/mdag_dp.sv
src/mdag_ctrl.sv
src/multi_dim_range_address_generator.sv
src/mdag_checker.sv
tb/sv/tb_multi_dim_range_address_generator.sv
